[rtl/svpc_pkg.sv]
`default_nettype none
package svpc_pkg;

  localparam int REF_FRAC_BITS = 14;
  localparam int COMPARE_WIDTH = 16;
  // fraction bits of all time values (ref bits + 16 bits of constant)
  localparam int FB = REF_FRAC_BITS + 16;
  localparam int TW = FB + 6;              // signed time width
  localparam int UW = TW - 1;              // clamped (non-negative) time width
  localparam int PW = UW + COMPARE_WIDTH;  // time * period
  localparam int QB = COMPARE_WIDTH + 2;   // quotient bits, ratio t1/(t1+t2) < 4
  localparam int RW = PW + 2;              // divider remainder width

  // pipeline: 3 front stages, 2 scale stages, QB divider stages, output
  localparam int NST = 5 + QB + 1;

  localparam logic signed [TW-1:0] K_INV_SQRT3 = TW'(37837);
  localparam logic signed [TW-1:0] K_TWO_SQRT3 = TW'(75674);
  localparam logic [16:0] K_SQRT3_2 = 17'd56756;
  localparam logic signed [TW-1:0] T_ONE = TW'(64'd1 << FB);

  localparam logic [COMPARE_WIDTH-1:0] PERIOD_RST = COMPARE_WIDTH'(4096);
  localparam logic [2:0] ADDR_PERIOD = 3'd0;

  localparam logic [1:0] PH_U = 2'd0;
  localparam logic [1:0] PH_V = 2'd1;
  localparam logic [1:0] PH_W = 2'd2;

  localparam logic [2:0] SEC_0 = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;

  typedef struct packed {
    logic signed [15:0] v_alpha;
    logic signed [15:0] v_beta;
    logic               run;
    logic               brake;
  } in_t;

  typedef struct packed {
    logic [15:0] compare_u;
    logic [15:0] compare_v;
    logic [15:0] compare_w;
    logic        driver_on;
    logic        low_side_on;
    logic [2:0]  sector;
    logic        overmodulated;
  } out_t;

  // front end -> scaler
  typedef struct packed {
    logic          act;
    logic          run;
    logic          over;
    logic [2:0]    sector;
    logic [UW-1:0] t0p;
    logic [UW-1:0] t1p;
    logic [UW-1:0] t2p;
    logic [UW-1:0] den;
  } tm_t;

  // side data carried alongside the divider
  typedef struct packed {
    logic                     act;
    logic                     run;
    logic                     over;
    logic [2:0]               sector;
    logic [COMPARE_WIDTH-1:0] first;
    logic [COMPARE_WIDTH-1:0] second;
    logic [COMPARE_WIDTH-1:0] third;
  } side_t;

  // phases that get first, second, third compare: {third, second, first}
  function automatic logic [5:0] phase_order(input logic [2:0] sec);
    logic [5:0] r;
    case (sec)
      SEC_0: r = {PH_W, PH_V, PH_U};
      SEC_1: r = {PH_W, PH_U, PH_V};
      SEC_2: r = {PH_U, PH_W, PH_V};
      SEC_3: r = {PH_U, PH_V, PH_W};
      SEC_4: r = {PH_V, PH_U, PH_W};
      SEC_5: r = {PH_V, PH_W, PH_U};
      default: r = {PH_W, PH_V, PH_U};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/svpc_front.sv]
`default_nettype none
module svpc_front (
  input  wire logic             clk,
  input  wire logic [2:0]       en,
  input  wire svpc_pkg::in_t    req,
  output svpc_pkg::tm_t         tm
);

  localparam int TW = svpc_pkg::TW;
  localparam int UW = svpc_pkg::UW;

  // stage 1: products
  logic [16:0] abs_a, abs_b;
  logic [33:0] ra, rb;
  logic signed [TW-1:0] a_x, b_x;
  logic signed [TW-1:0] ta, tbi, tbt;
  logic a_neg, b_neg, act1, run1;

  always_comb begin
    abs_a = req.v_alpha[15] ? (17'd0 - {1'b1, req.v_alpha}) : {1'b0, req.v_alpha};
    abs_b = req.v_beta[15] ? (17'd0 - {1'b1, req.v_beta}) : {1'b0, req.v_beta};
    a_x = TW'(req.v_alpha);
    b_x = TW'(req.v_beta);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ra    <= 34'(abs_a) * 34'(svpc_pkg::K_SQRT3_2);
      rb    <= {2'd0, abs_b, 15'd0};
      ta    <= a_x <<< 16;
      tbi   <= b_x * svpc_pkg::K_INV_SQRT3;
      tbt   <= b_x * svpc_pkg::K_TWO_SQRT3;
      a_neg <= req.v_alpha[15];
      b_neg <= req.v_beta[15];
      act1  <= req.run & ~req.brake;
      run1  <= req.run;
    end
  end

  // stage 2: sector and active times
  logic [2:0] sec_n, sec2;
  logic signed [TW-1:0] t1_n, t2_n, t1, t2;
  logic act2, run2;

  always_comb begin
    if (ra >= rb) begin
      if (!a_neg) sec_n = b_neg ? svpc_pkg::SEC_5 : svpc_pkg::SEC_0;
      else        sec_n = b_neg ? svpc_pkg::SEC_3 : svpc_pkg::SEC_2;
    end else begin
      sec_n = b_neg ? svpc_pkg::SEC_4 : svpc_pkg::SEC_1;
    end
    case (sec_n)
      svpc_pkg::SEC_0: begin t1_n = ta - tbi;  t2_n = tbt;       end
      svpc_pkg::SEC_1: begin t1_n = tbi - ta;  t2_n = ta + tbi;  end
      svpc_pkg::SEC_2: begin t1_n = tbt;       t2_n = -ta - tbi; end
      svpc_pkg::SEC_3: begin t1_n = -tbt;      t2_n = tbi - ta;  end
      svpc_pkg::SEC_4: begin t1_n = -ta - tbi; t2_n = ta - tbi;  end
      default:         begin t1_n = ta + tbi;  t2_n = -tbt;      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sec2 <= sec_n;
      t1   <= t1_n;
      t2   <= t2_n;
      act2 <= act1;
      run2 <= run1;
    end
  end

  // stage 3: zero time, clamp of negative terms
  logic signed [TW-1:0] t0_n, den_n;
  always_comb begin
    t0_n  = svpc_pkg::T_ONE - t1 - t2;
    den_n = t1 + t2;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      tm.act    <= act2;
      tm.run    <= run2;
      tm.sector <= sec2;
      tm.over   <= (t0_n <= 0);
      tm.t0p    <= (t0_n > 0) ? t0_n[UW-1:0] : '0;
      tm.t1p    <= (t1 > 0) ? t1[UW-1:0] : '0;
      tm.t2p    <= (t2 > 0) ? t2[UW-1:0] : '0;
      tm.den    <= den_n[UW-1:0];
    end
  end

endmodule
`default_nettype wire

[rtl/svpc_scale.sv]
`default_nettype none
module svpc_scale (
  input  wire logic                               clk,
  input  wire logic [1:0]                         en,
  input  wire logic [svpc_pkg::COMPARE_WIDTH-1:0] period,
  input  wire svpc_pkg::tm_t                      tm,
  output svpc_pkg::side_t                         side,
  output logic [svpc_pkg::RW-1:0]                 num,
  output logic [svpc_pkg::UW-1:0]                 den
);

  localparam int UW = svpc_pkg::UW;
  localparam int PW = svpc_pkg::PW;
  localparam int FB = svpc_pkg::FB;
  localparam int CW = svpc_pkg::COMPARE_WIDTH;

  // stage 4: times scaled by the period
  logic [PW-1:0] p0, p1, p2;
  logic [UW-1:0] den4;
  logic act4, run4, over4;
  logic [2:0] sec4;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0    <= PW'(tm.t0p) * PW'(period);
      p1    <= PW'(tm.t1p) * PW'(period);
      p2    <= PW'(tm.t2p) * PW'(period);
      den4  <= tm.den;
      act4  <= tm.act;
      run4  <= tm.run;
      over4 <= tm.over;
      sec4  <= tm.sector;
    end
  end

  // stage 5: stack half zero time and active times, saturating at period
  logic [PW-FB-2:0] f0;
  logic [PW-FB-1:0] s1, s2;
  logic [PW-FB+1:0] sum1, sum2;
  logic [CW-1:0] first_n, second_n, third_n;

  always_comb begin
    f0       = p0[PW-1:FB+1];
    s1       = p1[PW-1:FB];
    s2       = p2[PW-1:FB];
    first_n  = (f0 > (PW-FB-1)'(period)) ? period : f0[CW-1:0];
    sum1     = (PW-FB+2)'(first_n) + (PW-FB+2)'(s1);
    second_n = (sum1 > (PW-FB+2)'(period)) ? period : sum1[CW-1:0];
    sum2     = (PW-FB+2)'(second_n) + (PW-FB+2)'(s2);
    third_n  = (sum2 > (PW-FB+2)'(period)) ? period : sum2[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side.act    <= act4;
      side.run    <= run4;
      side.over   <= over4;
      side.sector <= sec4;
      side.first  <= first_n;
      side.second <= second_n;
      side.third  <= third_n;
      num         <= svpc_pkg::RW'(p1);
      den         <= den4;
    end
  end

endmodule
`default_nettype wire

[rtl/svpc_div.sv]
`default_nettype none
module svpc_div (
  input  wire logic                    clk,
  input  wire logic [svpc_pkg::QB-1:0] en,
  input  wire logic [svpc_pkg::RW-1:0] num,
  input  wire logic [svpc_pkg::UW-1:0] den,
  input  wire svpc_pkg::side_t         side_in,
  output logic [svpc_pkg::QB-1:0]      quo,
  output svpc_pkg::side_t              side_out
);

  localparam int QB = svpc_pkg::QB;
  localparam int RW = svpc_pkg::RW;
  localparam int UW = svpc_pkg::UW;

  // one quotient bit per stage, MSB first (restoring)
  logic [RW-1:0]   rem_q  [QB];
  logic [UW-1:0]   den_q  [QB];
  logic [QB-1:0]   q_q    [QB];
  svpc_pkg::side_t side_q [QB];

  for (genvar j = 0; j < QB; j++) begin : g_st
    logic [RW-1:0]   rem_i;
    logic [UW-1:0]   den_i;
    logic [QB-1:0]   q_i;
    svpc_pkg::side_t side_i;
    logic [RW-1:0]   dsh;

    if (j == 0) begin : g_first
      assign rem_i  = num;
      assign den_i  = den;
      assign q_i    = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_q[j-1];
      assign den_i  = den_q[j-1];
      assign q_i    = q_q[j-1];
      assign side_i = side_q[j-1];
    end

    assign dsh = RW'(den_i) << (QB - 1 - j);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        den_q[j]  <= den_i;
        side_q[j] <= side_i;
        if (rem_i >= dsh) begin
          rem_q[j] <= rem_i - dsh;
          q_q[j]   <= q_i | (QB'(1) << (QB - 1 - j));
        end else begin
          rem_q[j] <= rem_i;
          q_q[j]   <= q_i;
        end
      end
    end
  end

  assign quo      = q_q[QB-1];
  assign side_out = side_q[QB-1];

endmodule
`default_nettype wire

[rtl/space_vector_pwm_compare.sv]
`default_nettype none
// Channel   Direction  Handshake           Payload
// request   in         in_valid/in_stall   in_data  (svpc_pkg::in_t)
// result    out        out_valid/out_stall out_data (svpc_pkg::out_t)
// config    in         APB                 pwm_period at byte address 0
//
// One request per cycle sustained while out_stall is low. The pipe has
// 24 register stages (3 front, 2 scaling, 18 divider, output register).
// The overmodulation quotient is produced one bit per stage in the
// divider pipe.
// Reset (rst, synchronous) empties the pipe and sets pwm_period to 4096.
// Stall is passed back combinationally through the stage enables: empty stages
// keep filling, so a stalled output only stops the input once every stage
// holds a request.
// A request with brake set and run clear produces no result and is dropped
// at the input.
module space_vector_pwm_compare (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire svpc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output svpc_pkg::out_t      out_data,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int NST = svpc_pkg::NST;
  localparam int QB  = svpc_pkg::QB;
  localparam int CW  = svpc_pkg::COMPARE_WIDTH;

  // ---------------- configuration ----------------
  logic [CW-1:0] period;

  assign pready = 1'b1;
  assign prdata = (paddr == svpc_pkg::ADDR_PERIOD) ? 32'(period) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= svpc_pkg::PERIOD_RST;
    end else if (psel && penable && pwrite && paddr == svpc_pkg::ADDR_PERIOD) begin
      period <= pwdata[CW-1:0];
    end
  end

  // ---------------- stage valids and enables ----------------
  // en[k]: stage k register may load (it is empty or its content moves on)
  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = ~vld[NST-1] | ~out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  assign in_stall = ~en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid & (in_data.run | ~in_data.brake);
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------- datapath ----------------
  svpc_pkg::tm_t   tm;
  svpc_pkg::side_t side_s, side_d;
  logic [svpc_pkg::RW-1:0] num;
  logic [svpc_pkg::UW-1:0] den;
  logic [QB-1:0] quo;

  svpc_front u_front (
    .clk (clk),
    .en  (en[2:0]),
    .req (in_data),
    .tm  (tm)
  );

  svpc_scale u_scale (
    .clk    (clk),
    .en     (en[4:3]),
    .period (period),
    .tm     (tm),
    .side   (side_s),
    .num    (num),
    .den    (den)
  );

  svpc_div u_div (
    .clk      (clk),
    .en       (en[5+QB-1:5]),
    .num      (num),
    .den      (den),
    .side_in  (side_s),
    .quo      (quo),
    .side_out (side_d)
  );

  // ---------------- output stage ----------------
  logic [CW-1:0] first, second, third, q_sat;
  logic [5:0]    ord;
  logic [CW-1:0] cmp [3];
  svpc_pkg::out_t res;

  always_comb begin
    q_sat = (quo > QB'(period)) ? period : quo[CW-1:0];
    if (!side_d.act) begin
      first  = '0;
      second = '0;
      third  = '0;
    end else if (side_d.over) begin
      // rescaled: first phase off, last phase full period
      first  = '0;
      second = q_sat;
      third  = period;
    end else begin
      first  = side_d.first;
      second = side_d.second;
      third  = side_d.third;
    end
    ord = svpc_pkg::phase_order(side_d.sector);
    for (int p = 0; p < 3; p++) begin
      if (ord[1:0] == 2'(p))      cmp[p] = first;
      else if (ord[3:2] == 2'(p)) cmp[p] = second;
      else                        cmp[p] = third;
    end
    res.compare_u     = cmp[svpc_pkg::PH_U];
    res.compare_v     = cmp[svpc_pkg::PH_V];
    res.compare_w     = cmp[svpc_pkg::PH_W];
    res.driver_on     = side_d.run;
    res.low_side_on   = side_d.run;
    res.sector        = side_d.act ? side_d.sector : svpc_pkg::SEC_0;
    res.overmodulated = side_d.act & side_d.over;
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) out_data <= res;
  end

  assign out_valid = vld[NST-1];

  // ---------------- assertions ----------------
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.run && !in_data.brake |=> vld[0])
    else $error("run request did not enter the pipe");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overmodulated |->
      (out_data.compare_u == period || out_data.compare_v == period ||
       out_data.compare_w == period))
    else $error("overmodulated result without a full-period phase");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.driver_on |->
      (out_data.compare_u == '0 && out_data.compare_v == '0 &&
       out_data.compare_w == '0 && out_data.sector == svpc_pkg::SEC_0))
    else $error("stop result with nonzero compare");

endmodule
`default_nettype wire
